// File: hdl/ble_ad_uuid128_matcher_macros.svh
// Assertion macros for the advertising-data UUID matcher.
`ifndef BLE_AD_UUID128_MATCHER_MACROS_SVH
`define BLE_AD_UUID128_MATCHER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define BLEUUID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define BLEUUID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bleuuid_pkg.sv
// Shared types and constants of the advertising-data UUID matcher.
package bleuuid_pkg;

  localparam int unsigned UUID_LEN  = 16;
  localparam int unsigned CFG_WIDTH = 64;

  // AD structure types that carry 128-bit service UUID lists
  localparam logic [7:0] AD_TYPE_UUID128_PARTIAL  = 8'h06;
  localparam logic [7:0] AD_TYPE_UUID128_COMPLETE = 8'h07;

  // Smallest length field that holds a type byte plus a whole UUID
  localparam logic [7:0] MIN_UUID_FIELD_LEN = 8'd17;

  // Parse positions inside one AD structure
  localparam logic [7:0] POS_LENGTH = 8'd0;
  localparam logic [7:0] POS_TYPE   = 8'd1;
  localparam logic [7:0] POS_VALUE0 = 8'd2;

  // Configuration register indexes
  localparam logic CFG_UUID_LOW  = 1'b0;
  localparam logic CFG_UUID_HIGH = 1'b1;

  typedef logic [UUID_LEN-1:0][7:0] uuid_t;

  // Parser status toward the result stage
  typedef struct packed {
    logic found;     // match flag including the current word
    logic at_start;  // parser sits at a packet start
  } parse_stat_t;

endpackage

// File: hdl/bleuuid_if.sv
// Stream interfaces for payload bytes and match results.
interface bleuuid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bleuuid_out_if;
  logic valid;
  logic ready;
  logic service_found;

  modport source (output valid, output service_found, input ready);
  modport sink   (input valid, input service_found, output ready);
endinterface

// File: hdl/ble_ad_uuid128_matcher.sv
// Top level of the advertising-data 128-bit service UUID matcher.
// Throughput: one payload byte accepted per cycle, except while a held result is stalled by the sink.
// The result word is registered and becomes valid in the cycle after the last byte is accepted.
// Input ready drops only while a result is held and the sink stalls.
// Reset (rst, synchronous): parser at a length byte, UUID registers zero,
// no result pending.
`include "ble_ad_uuid128_matcher_macros.svh"

module ble_ad_uuid128_matcher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bleuuid_pkg::CFG_WIDTH-1:0] cfg_data,
  bleuuid_in_if.sink                        pkt_in,
  bleuuid_out_if.source                     res_out
);

  bleuuid_pkg::parse_stat_t stat;
  logic free;
  logic accept;
  logic load;

  assign pkt_in.ready = free;
  assign accept       = pkt_in.valid && free;
  assign load         = accept && pkt_in.last_byte;

  bleuuid_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (pkt_in.data_byte),
    .last_byte (pkt_in.last_byte),
    .stat      (stat)
  );

  bleuuid_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .stat  (stat),
    .free  (free),
    .res   (res_out)
  );

  // Checks
  `BLEUUID_ASSERT_NEXT(a_last_gives_result, clk, rst, load, res_out.valid, "no result after last byte")
  `BLEUUID_ASSERT_NEXT(a_last_clears_parser, clk, rst, load, stat.at_start, "parser not cleared at packet end")
  `BLEUUID_ASSERT_NOW(a_result_from_last, clk, rst, $rose(res_out.valid), $past(load), "result without last byte")
  `BLEUUID_ASSERT_NOW(a_ready_when_empty, clk, rst, !res_out.valid, pkt_in.ready, "input stalled with empty result stage")

endmodule

// File: hdl/bleuuid_parser.sv
// AD structure walker with UUID compare and configuration registers.
module bleuuid_parser (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [bleuuid_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                              accept,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  output bleuuid_pkg::parse_stat_t          stat
);

  bleuuid_pkg::uuid_t uuid;
  logic [7:0] field_position, field_position_next;
  logic [7:0] field_length, field_length_next;
  logic       field_is_uuid_list, field_is_uuid_list_next;
  logic       uuid_still_matching, uuid_still_matching_next;
  logic       match_seen, match_seen_next;
  logic       is_uuid_type;
  logic [7:0] value_offset;
  logic       found;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uuid <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bleuuid_pkg::CFG_UUID_LOW:  uuid[7:0]  <= cfg_data;
        bleuuid_pkg::CFG_UUID_HIGH: uuid[15:8] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_uuid_type = (data_byte == bleuuid_pkg::AD_TYPE_UUID128_PARTIAL) ||
                        (data_byte == bleuuid_pkg::AD_TYPE_UUID128_COMPLETE);
  assign value_offset = field_position - bleuuid_pkg::POS_VALUE0;

  // Next parse state for one accepted word
  always_comb begin
    field_position_next      = field_position;
    field_length_next        = field_length;
    field_is_uuid_list_next  = field_is_uuid_list;
    uuid_still_matching_next = uuid_still_matching;
    match_seen_next          = match_seen;
    found                    = match_seen;
    if (accept) begin
      if (field_position == bleuuid_pkg::POS_LENGTH) begin
        field_length_next   = data_byte;
        field_position_next = (data_byte == 8'd0) ? bleuuid_pkg::POS_LENGTH
                                                  : bleuuid_pkg::POS_TYPE;
      end else if (field_position == bleuuid_pkg::POS_TYPE) begin
        field_is_uuid_list_next  = is_uuid_type &&
                                   (field_length >= bleuuid_pkg::MIN_UUID_FIELD_LEN);
        uuid_still_matching_next = field_is_uuid_list_next;
        field_position_next      = (field_length <= 8'd1) ? bleuuid_pkg::POS_LENGTH
                                                          : bleuuid_pkg::POS_VALUE0;
      end else begin
        // Compare the first 16 value bytes against the UUID
        if (value_offset[7:4] == 4'd0 && field_is_uuid_list && uuid_still_matching) begin
          if (data_byte != uuid[value_offset[3:0]]) begin
            uuid_still_matching_next = 1'b0;
          end else if (value_offset[3:0] == 4'(bleuuid_pkg::UUID_LEN - 1)) begin
            match_seen_next = 1'b1;
          end
        end
        field_position_next = (field_position >= field_length) ? bleuuid_pkg::POS_LENGTH
                                                               : field_position + 8'd1;
      end
      found = match_seen_next;
      // Packet end clears the parse state
      if (last_byte) begin
        field_position_next      = bleuuid_pkg::POS_LENGTH;
        field_length_next        = 8'd0;
        field_is_uuid_list_next  = 1'b0;
        uuid_still_matching_next = 1'b0;
        match_seen_next          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_position      <= bleuuid_pkg::POS_LENGTH;
      field_length        <= 8'd0;
      field_is_uuid_list  <= 1'b0;
      uuid_still_matching <= 1'b0;
      match_seen          <= 1'b0;
    end else begin
      field_position      <= field_position_next;
      field_length        <= field_length_next;
      field_is_uuid_list  <= field_is_uuid_list_next;
      uuid_still_matching <= uuid_still_matching_next;
      match_seen          <= match_seen_next;
    end
  end

  assign stat.found    = found;
  assign stat.at_start = (field_position == bleuuid_pkg::POS_LENGTH) && !match_seen &&
                         (field_length == 8'd0);

endmodule

// File: hdl/bleuuid_out_stage.sv
// Result register: holds one match word until the sink takes it.
module bleuuid_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  bleuuid_pkg::parse_stat_t stat,
  output logic                     free,
  bleuuid_out_if.source            res
);

  logic valid, valid_next;
  logic service_found;

  assign free       = !valid || res.ready;
  assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      service_found <= stat.found;
    end
  end

  assign res.valid         = valid;
  assign res.service_found = service_found;

endmodule
